[hw/rtl/mrc_pkg.sv]
// Shared types, constants and the CRC-16/MODBUS byte update for the response checker.
package mrc_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] ADDR_RESET = 8'd1;
	localparam logic [7:0] FUNC_RESET = 8'd4;

	localparam int unsigned PADDR_W = 3;

	typedef enum logic {
		REG_EXP_ADDR = 1'b0,
		REG_EXP_FUNC = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_ADDR_ERR  = 2'd1,
		STATUS_FUNC_ERR  = 2'd2,
		STATUS_CRC_ERR   = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} mrc_beat_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] byte_count;
	} mrc_result_t;

	typedef struct packed {
		logic [7:0] exp_addr;
		logic [7:0] exp_func;
	} mrc_cfg_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[hw/rtl/mrc_if.sv]
// Valid/ready channel interfaces for received bytes and frame verdicts.
interface mrc_in_if;
	import mrc_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface mrc_out_if;
	import mrc_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] byte_count;

	modport source (output valid, output status, output byte_count, input ready);
	modport sink (input valid, input status, input byte_count, output ready);
endinterface

[hw/rtl/mrc_frame_engine.sv]
// Frame state tracking, CRC accumulation and verdict generation, one byte per step.
module mrc_frame_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  mrc_pkg::mrc_beat_t   beat,
	input  mrc_pkg::mrc_cfg_t    cfg,
	output logic                 res_valid,
	output mrc_pkg::mrc_result_t res
);
	import mrc_pkg::*;

	logic        in_frame_q;
	logic [8:0]  pos_q;
	logic [7:0]  cnt_q;
	logic [15:0] crc_q;
	logic        aok_q;
	logic        fok_q;
	logic        low_q;

	logic        in_frame;
	logic [8:0]  pos;
	logic [7:0]  cnt;
	logic [15:0] crc;
	logic        aok;
	logic        fok;
	logic        low;
	logic [7:0]  cnt_n;
	logic        aok_n;
	logic        fok_n;
	logic        low_n;
	logic [15:0] crc_n;
	logic [8:0]  crc_len;
	logic        last;
	logic        hi_match;

	always_comb begin
		in_frame = beat.frame_start | in_frame_q;
		pos      = beat.frame_start ? 9'd0 : pos_q;
		cnt      = beat.frame_start ? 8'd0 : cnt_q;
		crc      = beat.frame_start ? CRC_INIT : crc_q;
		aok      = beat.frame_start ? 1'b0 : aok_q;
		fok      = beat.frame_start ? 1'b0 : fok_q;
		low      = beat.frame_start ? 1'b0 : low_q;

		aok_n = aok;
		fok_n = fok;
		cnt_n = cnt;
		if (pos == 9'd0) begin
			aok_n = (beat.rx_byte == cfg.exp_addr);
		end else if (pos == 9'd1) begin
			fok_n = (beat.rx_byte == cfg.exp_func);
		end else if (pos == 9'd2) begin
			cnt_n = beat.rx_byte;
		end

		crc_len = {1'b0, cnt_n} + 9'd3;
		crc_n   = crc;
		low_n   = low;
		last    = 1'b0;
		if (pos < crc_len) begin
			crc_n = crc_byte(crc, beat.rx_byte);
		end else if (pos == crc_len) begin
			low_n = (beat.rx_byte == crc[7:0]);
		end else begin
			last = 1'b1;
		end

		hi_match       = (beat.rx_byte == crc[15:8]);
		res_valid      = step & in_frame & last;
		res.byte_count = cnt_n;
		if (!aok_n) begin
			res.status = STATUS_ADDR_ERR;
		end else if (!fok_n) begin
			res.status = STATUS_FUNC_ERR;
		end else if (!(low_n && hi_match)) begin
			res.status = STATUS_CRC_ERR;
		end else begin
			res.status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= 9'd0;
			cnt_q      <= 8'd0;
			crc_q      <= CRC_INIT;
			aok_q      <= 1'b0;
			fok_q      <= 1'b0;
			low_q      <= 1'b0;
		end else if (step && in_frame) begin
			cnt_q <= cnt_n;
			crc_q <= crc_n;
			aok_q <= aok_n;
			fok_q <= fok_n;
			low_q <= low_n;
			if (last) begin
				in_frame_q <= 1'b0;
				pos_q      <= 9'd0;
			end else begin
				in_frame_q <= 1'b1;
				pos_q      <= pos + 9'd1;
			end
		end
	end

endmodule

[hw/rtl/modbus_rtu_response_checker_core.sv]
// Modbus RTU response checker: top level with input register, result register and APB registers.
//
// Usage:
//   in_ch carries one received byte per beat; frame_start marks the address
//   byte of a new frame and restarts any check in progress. Bytes seen while
//   no frame is open are dropped. out_ch carries one verdict per frame, given
//   on the high CRC byte: status (ok, address, function or CRC mismatch, in
//   that priority) and the frame's byte count field.
//   Registers: 0x0 expected address (reset 1), 0x4 expected function (reset 4).
//   Writes are two-phase APB, pready is tied high; reads return the register.
// Timing:
//   A byte is taken into the input register, processed there by the CRC/compare
//   logic once it may advance, and its verdict lands in the result register:
//   out_ch.valid rises on the edge at which the last byte leaves the input register.
//   One byte per cycle is sustained while out_ch is not stalled; the combinational
//   byte-wide CRC update sets that figure.
// Reset and stall:
//   arst_n closes any frame, restores the CRC seed and register defaults.
//   While out_ch holds a verdict that is not taken, the input register holds
//   its byte and in_ch.ready drops once that register is occupied.
module modbus_rtu_response_checker_core (
	input  logic                        clk,
	input  logic                        arst_n,
	mrc_in_if.sink                      in_ch,
	mrc_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mrc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import mrc_pkg::*;

	mrc_cfg_t    cfg_q;
	mrc_beat_t   beat_s1;
	logic        valid_s1;
	logic        advance;
	logic        res_valid;
	mrc_result_t res;
	mrc_result_t res_q;
	logic        out_valid_q;
	reg_idx_t    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		case (reg_idx)
			REG_EXP_ADDR: prdata = {24'd0, cfg_q.exp_addr};
			REG_EXP_FUNC: prdata = {24'd0, cfg_q.exp_func};
			default:      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exp_addr <= ADDR_RESET;
			cfg_q.exp_func <= FUNC_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_EXP_ADDR: cfg_q.exp_addr <= pwdata[7:0];
				REG_EXP_FUNC: cfg_q.exp_func <= pwdata[7:0];
				default:      ;
			endcase
		end
	end

	assign advance     = valid_s1 & (~out_valid_q | out_ch.ready);
	assign in_ch.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			beat_s1.rx_byte     <= in_ch.rx_byte;
			beat_s1.frame_start <= in_ch.frame_start;
		end
	end

	mrc_frame_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.beat      (beat_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.status     = res_q.status;
	assign out_ch.byte_count = res_q.byte_count;

endmodule

[sim/tb.sv]
// Testbench for the Modbus RTU response checker: frame stimulus, APB setup and verdict scoreboard.
`timescale 1ns / 1ps

import mrc_pkg::*;

class verdict_tracker;
	logic [7:0]  exp_addr;
	logic [7:0]  exp_func;
	bit          in_frame;
	bit          addr_ok;
	bit          func_ok;
	bit          crc_lo_ok;
	logic [8:0]  pos;
	logic [7:0]  count;
	logic [15:0] crc;
	mrc_result_t pending[$];
	int unsigned faults;
	int unsigned seen[4];

	function new();
		exp_addr = ADDR_RESET;
		exp_func = FUNC_RESET;
		in_frame = 0;
		addr_ok = 0;
		func_ok = 0;
		crc_lo_ok = 0;
		pos = '0;
		count = '0;
		crc = CRC_INIT;
		faults = 0;
		foreach (seen[i]) seen[i] = 0;
	endfunction

	static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] d);
		logic lsb;
		c = c ^ {8'h00, d};
		repeat (8) begin
			lsb = c[0];
			c = c >> 1;
			if (lsb) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function void set_reg(reg_idx_t idx, logic [31:0] v);
		case (idx)
			REG_EXP_ADDR: exp_addr = v[7:0];
			REG_EXP_FUNC: exp_func = v[7:0];
			default: ;
		endcase
	endfunction

	// 0: dropped outside a frame, 1: consumed, 2: consumed and closes the frame
	function int take_byte(logic [7:0] b, logic start);
		logic [8:0]  crc_len;
		mrc_result_t r;
		if (start) begin
			in_frame = 1;
			pos = '0;
			crc = CRC_INIT;
			count = '0;
			addr_ok = 0;
			func_ok = 0;
			crc_lo_ok = 0;
		end
		if (!in_frame) return 0;
		case (pos)
			9'd0: addr_ok = (b == exp_addr);
			9'd1: func_ok = (b == exp_func);
			9'd2: count = b;
			default: ;
		endcase
		crc_len = {1'b0, count} + 9'd3;
		if (pos < crc_len) begin
			crc = crc16_step(crc, b);
		end else if (pos == crc_len) begin
			crc_lo_ok = (b == crc[7:0]);
		end else begin
			if (!addr_ok) r.status = STATUS_ADDR_ERR;
			else if (!func_ok) r.status = STATUS_FUNC_ERR;
			else if (!(crc_lo_ok && b == crc[15:8])) r.status = STATUS_CRC_ERR;
			else r.status = STATUS_OK;
			r.byte_count = count;
			pending.push_back(r);
			in_frame = 0;
			pos = '0;
			return 2;
		end
		pos = pos + 9'd1;
		return 1;
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		faults++;
	endtask

	task check_verdict(logic [1:0] st, logic [7:0] bc);
		mrc_result_t e;
		if (pending.size() == 0) begin
			report($sformatf("verdict status %0d count %0d with no frame closed", st, bc));
			return;
		end
		e = pending.pop_front();
		seen[e.status]++;
		if (st != e.status)
			report($sformatf("status %0d, want %0d (count %0d)", st, e.status, e.byte_count));
		if (bc != e.byte_count)
			report($sformatf("byte_count %0d, want %0d", bc, e.byte_count));
	endtask
endclass

module tb;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned PHASE_BEATS  = 285;
	localparam int unsigned NUM_PHASES   = 6;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	mrc_in_if  in_ch();
	mrc_out_if out_ch();

	verdict_tracker sb;

	int unsigned hold_left;
	int unsigned free_left;
	int unsigned ready_pick;
	int unsigned used_beats;
	int unsigned ignored_beats;
	int unsigned phase_used;
	int unsigned settings_seen;
	int unsigned big_left;
	bit          calm;

	modbus_rtu_response_checker_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d verdicts pending", CYCLE_LIMIT, sb.pending.size());
		$display("FAILED: results differ");
		$finish;
	end

	// result side back-pressure: short and long stalls, with stall-free stretches
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			out_ch.ready <= 1'b1;
			if (free_left > 0) begin
				free_left--;
			end else begin
				ready_pick = $urandom_range(0, 99);
				if (ready_pick < 4) free_left = $urandom_range(100, 300);
				else if (ready_pick < 55) hold_left = 0;
				else if (ready_pick < 90) hold_left = $urandom_range(1, 3);
				else hold_left = $urandom_range(8, 40);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_verdict(out_ch.status, out_ch.byte_count);
	end

	task automatic gap();
		int unsigned r;
		int unsigned n;
		if (calm) return;
		r = $urandom_range(0, 99);
		if (r < 55) n = 0;
		else if (r < 88) n = $urandom_range(1, 3);
		else n = $urandom_range(6, 40);
		if (n > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic quiet();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	task automatic send_beat(logic [7:0] b, logic s);
		int r;
		@(negedge clk);
		in_ch.valid       <= 1'b1;
		in_ch.rx_byte     <= b;
		in_ch.frame_start <= s;
		do @(posedge clk); while (!in_ch.ready);
		r = sb.take_byte(b, s);
		if (r == 0) begin
			ignored_beats++;
		end else begin
			used_beats++;
			phase_used++;
		end
		gap();
	endtask

	// keep = 0 sends the whole frame, otherwise only its first keep bytes
	task automatic send_frame(logic [7:0] a, logic [7:0] f, logic [7:0] n,
			logic [1:0] crc_fault, int unsigned keep);
		logic [7:0]  bytes[$];
		logic [7:0]  d;
		logic [15:0] c;
		int unsigned i;
		bytes.push_back(a);
		bytes.push_back(f);
		bytes.push_back(n);
		for (i = 0; i < n; i++) begin
			d = 8'($urandom_range(0, 255));
			bytes.push_back(d);
		end
		c = CRC_INIT;
		for (i = 0; i < bytes.size(); i++) c = sb.crc16_step(c, bytes[i]);
		d = crc_fault[0] ? 8'($urandom_range(1, 255)) : 8'd0;
		bytes.push_back(c[7:0] ^ d);
		d = crc_fault[1] ? 8'($urandom_range(1, 255)) : 8'd0;
		bytes.push_back(c[15:8] ^ d);
		if (keep == 0 || keep > bytes.size()) keep = bytes.size();
		for (i = 0; i < keep; i++) send_beat(bytes[i], i == 0);
	endtask

	task automatic random_item();
		int unsigned r;
		int unsigned k;
		int unsigned keep;
		logic [7:0]  a;
		logic [7:0]  f;
		logic [7:0]  n;
		logic [1:0]  fault;
		calm = ($urandom_range(0, 5) == 0);
		r = $urandom_range(0, 99);
		if (r < 5) begin
			k = $urandom_range(1, 10);
			repeat (k) send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			return;
		end
		a = ($urandom_range(0, 99) < 88) ? sb.exp_addr : 8'($urandom_range(0, 255));
		f = ($urandom_range(0, 99) < 88) ? sb.exp_func : 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r == 0 && big_left > 0) begin
			n = 8'($urandom_range(100, 255));
			big_left--;
		end else if (r < 72) begin
			n = 8'($urandom_range(0, 6));
		end else begin
			n = 8'($urandom_range(7, 40));
		end
		fault = ($urandom_range(0, 99) < 78) ? 2'd0 : 2'($urandom_range(1, 3));
		keep = ($urandom_range(0, 99) < 8) ? $urandom_range(1, n + 4) : 0;
		send_frame(a, f, n, fault, keep);
		if ($urandom_range(0, 99) < 12) begin
			k = $urandom_range(1, 3);
			repeat (k) send_beat(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic drain();
		quiet();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(logic wr, reg_idx_t idx, logic [31:0] wd, output logic [31:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wd;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		if (wr) sb.set_reg(idx, wd);
	endtask

	task automatic check_register(reg_idx_t idx, logic [7:0] v);
		logic [31:0] rd;
		apb_access(1'b0, idx, 32'h0, rd);
		if (rd !== {24'h0, v})
			sb.report($sformatf("register %0d reads %h, want %h", idx, rd, v));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_register(reg_idx_t idx, logic [7:0] v);
		logic [31:0] wd;
		logic [31:0] rd;
		wd = $urandom();
		wd[7:0] = v;
		apb_access(1'b1, idx, wd, rd);
		check_register(idx, v);
	endtask

	initial begin
		int unsigned p;
		logic [7:0]  av;
		logic [7:0]  fv;
		sb = new();
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.rx_byte     = 8'h00;
		in_ch.frame_start = 1'b0;
		out_ch.ready      = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = 32'h0;
		hold_left         = 0;
		free_left         = 0;
		used_beats        = 0;
		ignored_beats     = 0;
		settings_seen     = 1;
		big_left          = 2;
		calm              = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_register(REG_EXP_ADDR, ADDR_RESET);
		check_register(REG_EXP_FUNC, FUNC_RESET);

		for (p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				drain();
				case (p)
					1: begin av = 8'h00; fv = 8'hFF; end
					2: begin av = 8'hFF; fv = 8'h00; end
					default: begin
						av = 8'($urandom_range(0, 255));
						fv = 8'($urandom_range(0, 255));
					end
				endcase
				set_register(REG_EXP_ADDR, av);
				set_register(REG_EXP_FUNC, fv);
				settings_seen++;
			end
			phase_used = 0;
			if (p == 0) begin
				// stray byte, clean frame, address+function+CRC all wrong,
				// function+CRC wrong, cut frame restarted, CRC low byte wrong
				send_beat(8'hFF, 1'b0);
				send_frame(ADDR_RESET, FUNC_RESET, 8'd0, 2'd0, 0);
				send_frame(8'h00, 8'hFF, 8'd0, 2'd3, 0);
				send_frame(ADDR_RESET, 8'hFF, 8'd0, 2'd2, 0);
				send_frame(ADDR_RESET, FUNC_RESET, 8'd1, 2'd0, 3);
				send_frame(ADDR_RESET, FUNC_RESET, 8'd0, 2'd1, 0);
			end
			if (p == 2) send_frame(sb.exp_addr, sb.exp_func, 8'hFF, 2'd0, 0);
			while (phase_used < PHASE_BEATS) random_item();
		end
		drain();

		$display("Ran %0d frame beats (%0d stray beats dropped) under %0d register settings.",
			used_beats, ignored_beats, settings_seen);
		$display("Verdicts: %0d ok, %0d address, %0d function, %0d CRC mismatch.",
			sb.seen[STATUS_OK], sb.seen[STATUS_ADDR_ERR], sb.seen[STATUS_FUNC_ERR],
			sb.seen[STATUS_CRC_ERR]);
		if (sb.faults == 0 && sb.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
